// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/mfe_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI file encoder package
// Shared types, request codes and the constant file-header bytes.
// ----------------------------------------------------------------------------
package mfe_pkg;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_EVENT = 2'd1,
        REQ_END   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    localparam int IdxW       = 6;
    localparam int DivIters   = 29;   // two quotient bits per iteration, 58-bit dividend
    localparam int DivCntW    = 5;
    localparam logic [IdxW-1:0] StartBytes = 6'd37;
    localparam logic [IdxW-1:0] EndBytes   = 6'd8;

    localparam logic [7:0] KindMin   = 8'h80;
    localparam logic [7:0] KindMax   = 8'hE0;
    localparam logic [7:0] KindBend  = 8'hE0;
    localparam logic [7:0] KindProg  = 8'hC0;
    localparam logic [7:0] KindPress = 8'hD0;
    localparam logic [15:0] BendMax  = 16'h3FFF;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic            load;
        logic            mul;
        logic            div_step;
        logic            emit;
        logic            last;
        logic [IdxW-1:0] idx;
    } cmd_t;

    // Status bundle from the datapath to the controller.
    typedef struct packed {
        req_t            in_req;
        logic            in_kind_ok;
        logic [IdxW-1:0] total;
        logic            out_free;
    } sts_t;

    // Bytes of the start sequence: header chunk, track chunk header, tempo and time signature.
    function automatic logic [7:0] start_byte(input logic [IdxW-1:0] idx,
                                              input logic [14:0] ppq,
                                              input logic [23:0] tempo);
        logic [7:0] b;
        begin
            case (idx)
                6'd0:  b = 8'h4D;
                6'd1:  b = 8'h54;
                6'd2:  b = 8'h68;
                6'd3:  b = 8'h64;
                6'd7:  b = 8'h06;
                6'd11: b = 8'h01;
                6'd12: b = {1'b0, ppq[14:8]};
                6'd13: b = ppq[7:0];
                6'd14: b = 8'h4D;
                6'd15: b = 8'h54;
                6'd16: b = 8'h72;
                6'd17: b = 8'h6B;
                6'd23: b = 8'hFF;
                6'd24: b = 8'h51;
                6'd25: b = 8'h03;
                6'd26: b = tempo[23:16];
                6'd27: b = tempo[15:8];
                6'd28: b = tempo[7:0];
                6'd30: b = 8'hFF;
                6'd31: b = 8'h58;
                6'd32: b = 8'h04;
                6'd33: b = 8'h04;
                6'd34: b = 8'h02;
                6'd35: b = 8'h18;
                6'd36: b = 8'h08;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

// ===== hdl/mfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// MIDI file encoder controller
// Sequences capture, multiply and division (channel events only) and byte emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfe_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  mfe_pkg::sts_t sts,
    output mfe_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [mfe_pkg::IdxW-1:0]      idx_reg, idx_next;
    logic [mfe_pkg::DivCntW-1:0]   div_cnt_reg, div_cnt_next;
    logic                          accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next-state and command logic.
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.idx      = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    case (sts.in_req)
                        mfe_pkg::REQ_START, mfe_pkg::REQ_END: state_next = S_EMIT;
                        mfe_pkg::REQ_EVENT: begin
                            if (sts.in_kind_ok) begin
                                state_next = S_MUL;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == mfe_pkg::DivCntW'(mfe_pkg::DivIters - 1)) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = (idx_reg == sts.total - 1'b1);
                    idx_next = idx_reg + 1'b1;
                    if (cmd.last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // The divider never runs past its last iteration.
    `ASSERT_IMPL(a_div_bound, aclk, aresetn, state_reg == S_DIV,
                 div_cnt_reg < mfe_pkg::DivCntW'(mfe_pkg::DivIters))
    // Emission never goes beyond the byte total of the current request.
    `ASSERT_IMPL(a_idx_bound, aclk, aresetn, state_reg == S_EMIT, idx_reg < sts.total)
    // The final byte of a request returns the controller to idle.
    `ASSERT_NEXT(a_last_idle, aclk, aresetn, cmd.emit && cmd.last, state_reg == S_IDLE)
    // A byte is only loaded when the output register can take it.
    `ASSERT_IMPL(a_emit_free, aclk, aresetn, cmd.emit, sts.out_free)

endmodule

// ===== hdl/mfe_dp.sv =====
// ----------------------------------------------------------------------------
// MIDI file encoder datapath
// Configuration, tick conversion, radix-4 divider, byte selection and output.
// ----------------------------------------------------------------------------
module mfe_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    input  logic [79:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    input  mfe_pkg::cmd_t cmd,
    output mfe_pkg::sts_t sts,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);

    logic [14:0] ppq_reg;
    logic [23:0] tempo_reg;
    logic [1:0]  req_reg;
    logic [7:0]  kind_reg;
    logic [3:0]  chan_reg;
    logic [6:0]  d1_reg, d2_reg;
    logic [13:0] bend_reg;
    logic [31:0] time_reg;
    logic [24:0] k_reg;
    logic [57:0] dvd_reg, dvd_next;
    logic [24:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] prev_reg, cnt_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tuser_reg, m_tlast_reg;

    logic [7:0]  in_kind;
    logic [15:0] in_bend;
    logic [23:0] divisor;
    logic [31:0] tick, delta, end_len;
    logic [2:0]  vlq_n, grp_idx;
    logic [6:0]  grp;
    logic        is_bend;
    logic [5:0]  ev_total, ev_j;
    logic [7:0]  byte_sel;

    assign in_kind = s_tdata[39:32];
    assign in_bend = s_tdata[79:64];
    assign divisor = (tempo_reg == '0) ? 24'd1 : tempo_reg;
    assign is_bend = (kind_reg == mfe_pkg::KindBend);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppq_reg   <= 15'd480;
            tempo_reg <= 24'd500000;
        end else if (cfg_we) begin
            if (cfg_index == 2'd0) begin
                ppq_reg <= cfg_data[14:0];
            end else if (cfg_index == 2'd1) begin
                tempo_reg <= cfg_data;
            end
        end
    end

    // Two restoring division steps per cycle.
    always_comb begin
        logic [24:0] r;
        logic [57:0] d;
        logic [31:0] q;
        r = rem_reg;
        d = dvd_reg;
        q = quo_reg;
        for (int i = 0; i < 2; i++) begin
            r = {r[23:0], d[57]};
            d = {d[56:0], 1'b0};
            if (r >= {1'b0, divisor}) begin
                r = r - {1'b0, divisor};
                q = {q[30:0], 1'b1};
            end else begin
                q = {q[30:0], 1'b0};
            end
        end
        rem_next = r;
        dvd_next = d;
        quo_next = q;
    end

    // Capture, multiply and divide.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_tuser;
            time_reg <= s_tdata[31:0];
            kind_reg <= in_kind;
            chan_reg <= s_tdata[43:40];
            d1_reg   <= s_tdata[54:48];
            d2_reg   <= s_tdata[62:56];
            bend_reg <= (in_bend > mfe_pkg::BendMax) ? 14'h3FFF : in_bend[13:0];
            k_reg    <= 25'(ppq_reg) * 25'd1000;
        end
        if (cmd.mul) begin
            dvd_reg <= {1'b0, 57'(time_reg) * 57'(k_reg)};
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Delta time, its variable-length group count, the event byte total and the end length.
    always_comb begin
        tick  = (quo_reg < prev_reg) ? prev_reg : quo_reg;
        delta = tick - prev_reg;
        if (delta[31:28] != '0) begin
            vlq_n = 3'd5;
        end else if (delta[27:21] != '0) begin
            vlq_n = 3'd4;
        end else if (delta[20:14] != '0) begin
            vlq_n = 3'd3;
        end else if (delta[13:7] != '0) begin
            vlq_n = 3'd2;
        end else begin
            vlq_n = 3'd1;
        end
        ev_total = {3'b0, vlq_n} + ((is_bend || (kind_reg != mfe_pkg::KindProg &&
                   kind_reg != mfe_pkg::KindPress)) ? 6'd3 : 6'd2);
        end_len  = cnt_reg + 32'd4;
    end

    // Byte selection for the current index.
    always_comb begin
        grp_idx = vlq_n - 3'd1 - cmd.idx[2:0];
        ev_j    = cmd.idx - {3'b0, vlq_n};
        case (grp_idx)
            3'd0:    grp = delta[6:0];
            3'd1:    grp = delta[13:7];
            3'd2:    grp = delta[20:14];
            3'd3:    grp = delta[27:21];
            default: grp = {3'b0, delta[31:28]};
        endcase
        case (mfe_pkg::req_t'(req_reg))
            mfe_pkg::REQ_START: begin
                byte_sel = mfe_pkg::start_byte(cmd.idx, ppq_reg, tempo_reg);
            end
            mfe_pkg::REQ_EVENT: begin
                if (cmd.idx < {3'b0, vlq_n}) begin
                    byte_sel = {(grp_idx != 3'd0), grp};
                end else if (ev_j == 6'd0) begin
                    byte_sel = kind_reg | {4'b0, chan_reg};
                end else if (ev_j == 6'd1) begin
                    byte_sel = {1'b0, is_bend ? bend_reg[6:0] : d1_reg};
                end else begin
                    byte_sel = {1'b0, is_bend ? bend_reg[13:7] : d2_reg};
                end
            end
            default: begin
                case (cmd.idx)
                    6'd1:    byte_sel = 8'hFF;
                    6'd2:    byte_sel = 8'h2F;
                    6'd4:    byte_sel = end_len[31:24];
                    6'd5:    byte_sel = end_len[23:16];
                    6'd6:    byte_sel = end_len[15:8];
                    6'd7:    byte_sel = end_len[7:0];
                    default: byte_sel = 8'h00;
                endcase
            end
        endcase
    end

    // Track state, updated when a request's last byte goes out.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            cnt_reg  <= '0;
        end else if (cmd.emit && cmd.last) begin
            case (mfe_pkg::req_t'(req_reg))
                mfe_pkg::REQ_START: begin
                    prev_reg <= '0;
                    cnt_reg  <= 32'd15;
                end
                mfe_pkg::REQ_EVENT: begin
                    prev_reg <= tick;
                    cnt_reg  <= cnt_reg + {26'b0, ev_total};
                end
                default: cnt_reg <= end_len;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_tdata_reg <= byte_sel;
            m_tuser_reg <= (req_reg == mfe_pkg::REQ_END) && cmd.idx[2];
            m_tlast_reg <= cmd.last;
        end
    end

    // Status toward the controller.
    always_comb begin
        sts.in_req     = mfe_pkg::req_t'(s_tuser);
        sts.in_kind_ok = (in_kind >= mfe_pkg::KindMin) && (in_kind <= mfe_pkg::KindMax);
        sts.out_free   = !m_tvalid_reg || m_tready;
        case (mfe_pkg::req_t'(req_reg))
            mfe_pkg::REQ_START: sts.total = mfe_pkg::StartBytes;
            mfe_pkg::REQ_EVENT: sts.total = ev_total;
            default:            sts.total = mfe_pkg::EndBytes;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== hdl/midi_file_event_encoder_top.sv =====
// ----------------------------------------------------------------------------
// MIDI file event encoder
// Turns start, channel-event and end requests into a format-0 MIDI file stream.
// ----------------------------------------------------------------------------
// One request is handled at a time and the next one is taken as soon as the
// last byte of the current one sits in the output register. A start request
// emits 37 bytes, one per cycle while the output is not stalled. An end
// request emits 8 bytes. A channel event has a capture step, a multiply step,
// the two-bit-per-cycle restoring divider that turns milliseconds into ticks,
// then 3 to 8 output bytes. Events with a status outside 0x80..0xE0 and
// reserved requests are consumed without output. Output back-pressure holds
// back byte emission.
module midi_file_event_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // time_ms[31:0], msg_kind[39:32], channel[47:40], data_one[55:48],
    // data_two[63:56], bend_value[79:64]
    input  logic [79:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0]
    output logic [7:0]  m_tdata,
    // to_length_field[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    mfe_pkg::cmd_t cmd;
    mfe_pkg::sts_t sts;

    mfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mfe_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// MIDI file event encoder testbench
// Drives start, channel-event, end and reserved requests with random gaps and
// output stalls, predicts every file byte in a local model and compares each
// byte, length flag and last marker as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    typedef struct packed {
        logic [7:0] data;
        logic       len_flag;
        logic       last;
    } file_byte_t;

    file_byte_t  pending_bytes[$];
    logic [14:0] ppq;
    logic [23:0] tempo;
    logic [31:0] prev_tick;
    logic [31:0] track_len;
    int          mismatches = 0;
    int          out_wait = 0;
    bit          stall_free = 1'b0;

    midi_file_event_encoder_top uut (.*);

    always #1 aclk = ~aclk;

    // Queue one predicted byte of the file stream.
    function automatic void push_byte(logic [7:0] b, logic flag);
        file_byte_t fb;
        fb.data = b;
        fb.len_flag = flag;
        fb.last = 1'b0;
        pending_bytes.push_back(fb);
    endfunction

    // Predict the bytes caused by one request and update the track state.
    function automatic void predict_request(mfe_pkg::req_t req, logic [79:0] d);
        logic [7:0]  kind, stat;
        logic [15:0] bend;
        logic [63:0] prod, divisor;
        logic [31:0] tick, delta;
        logic [7:0]  groups[5];
        int          n, i, before_cnt;
        before_cnt = pending_bytes.size();
        kind = d[39:32];
        case (req)
            mfe_pkg::REQ_START: begin
                prev_tick = '0;
                track_len = 32'd15;
                for (i = 0; i < 37; i++) begin
                    push_byte(mfe_pkg::start_byte(i[5:0], ppq, tempo), 1'b0);
                end
            end
            mfe_pkg::REQ_EVENT: begin
                if (kind >= mfe_pkg::KindMin && kind <= mfe_pkg::KindMax) begin
                    prod = 64'(d[31:0]) * 64'(ppq) * 64'd1000;
                    divisor = (tempo == 0) ? 64'd1 : 64'(tempo);
                    tick = 32'(prod / divisor);
                    if (tick < prev_tick) tick = prev_tick;
                    delta = tick - prev_tick;
                    n = 0;
                    groups[n++] = {1'b0, delta[6:0]};
                    delta = delta >> 7;
                    while (delta != 0 && n < 5) begin
                        groups[n++] = {1'b1, delta[6:0]};
                        delta = delta >> 7;
                    end
                    for (i = n - 1; i >= 0; i--) push_byte(groups[i], 1'b0);
                    stat = kind | {4'd0, d[43:40]};
                    push_byte(stat, 1'b0);
                    if (kind == mfe_pkg::KindBend) begin
                        bend = (d[79:64] > mfe_pkg::BendMax) ? mfe_pkg::BendMax : d[79:64];
                        push_byte({1'b0, bend[6:0]}, 1'b0);
                        push_byte({1'b0, bend[13:7]}, 1'b0);
                    end else begin
                        push_byte({1'b0, d[54:48]}, 1'b0);
                        if (kind != mfe_pkg::KindProg && kind != mfe_pkg::KindPress)
                            push_byte({1'b0, d[62:56]}, 1'b0);
                    end
                    prev_tick = tick;
                    track_len += 32'(pending_bytes.size() - before_cnt);
                end
            end
            mfe_pkg::REQ_END: begin
                push_byte(8'h00, 1'b0);
                push_byte(8'hFF, 1'b0);
                push_byte(8'h2F, 1'b0);
                push_byte(8'h00, 1'b0);
                track_len += 32'd4;
                push_byte(track_len[31:24], 1'b1);
                push_byte(track_len[23:16], 1'b1);
                push_byte(track_len[15:8], 1'b1);
                push_byte(track_len[7:0], 1'b1);
            end
            default: ;
        endcase
        if (pending_bytes.size() > before_cnt)
            pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    // Send one request transaction after a random gap. The valid stays high
    // after acceptance so that a following request can start in the same step.
    task automatic send_request(mfe_pkg::req_t req, logic [79:0] d, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(req, d);
    endtask

    function automatic logic [79:0] pack_event(logic [31:0] ms, logic [7:0] kind,
                                               logic [7:0] chan, logic [7:0] d1,
                                               logic [7:0] d2, logic [15:0] bend);
        return {bend, d2, d1, chan, kind, ms};
    endfunction

    function automatic logic [79:0] random_event();
        logic [7:0] kind;
        kind = {4'($urandom_range(8, 14)), 4'($urandom)};
        if ($urandom_range(0, 9) == 0) kind = 8'($urandom);
        return pack_event($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000),
                          kind, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    endfunction

    // Release the input, wait until every predicted byte has arrived, then
    // let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == 2'd0) ppq = value[14:0];
        else if (idx == 2'd1) tempo = value;
    endtask

    // Directed: every request kind, field extremes and the special cases.
    task automatic test_directed();
        send_request(mfe_pkg::REQ_START, '0);
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd0, 8'h90, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd1000, 8'h80, 8'h00, 8'h00, 8'h00, 16'h0));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd500, 8'hA0, 8'h05, 8'h7F, 8'h80, 16'h0));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd2000, 8'hB3, 8'h0C, 8'h11, 8'h22, 16'h0));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd2500, 8'hC0, 8'h01, 8'h33, 8'h44, 16'h0));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd3000, 8'hD0, 8'h02, 8'h55, 8'h66, 16'h0));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd3100, 8'hE0, 8'h03, 8'h00, 8'h00, 16'hFFFF));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd3200, 8'hE0, 8'h03, 8'h00, 8'h00, 16'h2ABC));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd3300, 8'h7F, 8'h03, 8'h01, 8'h02, 16'h0));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd3300, 8'hE1, 8'h03, 8'h01, 8'h02, 16'h0));
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'hFFFFFFFF, 8'h90, 8'h0F, 8'h40, 8'h40, 16'h0));
        send_request(mfe_pkg::REQ_NONE, '1);
        send_request(mfe_pkg::REQ_END, '1);
        send_request(mfe_pkg::REQ_EVENT,
                     pack_event(32'd10, 8'h90, 8'h00, 8'h01, 8'h01, 16'h0));
        send_request(mfe_pkg::REQ_END, '0);
    endtask

    // Extreme register settings, including zero ppq and zero tempo.
    task automatic test_config_extremes();
        logic [23:0] ppqs[4] = '{24'd0, 24'd1, 24'h7FFF, 24'hFFFFFF};
        logic [23:0] tempos[4] = '{24'd0, 24'd1, 24'hFFFFFF, 24'd500000};
        for (int i = 0; i < 4; i++) begin
            drain();
            write_reg(2'd0, ppqs[i]);
            write_reg(2'd1, tempos[i]);
            write_reg(2'd2, 24'($urandom));
            send_request(mfe_pkg::REQ_START, '0);
            send_request(mfe_pkg::REQ_EVENT,
                         pack_event(32'hFFFFFFFF, 8'h90, 8'h01, 8'h3C, 8'h64, 16'h0));
            send_request(mfe_pkg::REQ_EVENT,
                         pack_event(32'd7, 8'hE0, 8'h01, 8'h0, 8'h0, 16'h4000));
            send_request(mfe_pkg::REQ_END, '0);
        end
    endtask

    // Random tracks: a start, a run of events with mostly rising times, an end.
    task automatic test_random_tracks();
        int sent;
        int len;
        logic [79:0] d;
        logic [31:0] ms;
        sent = 0;
        while (sent < 380) begin
            if (sent % 100 == 0) begin
                drain();
                write_reg(2'd0, 24'($urandom_range(1, 960)));
                write_reg(2'd1, 24'($urandom_range(100000, 1000000)));
            end
            stall_free = ($urandom_range(0, 3) == 0);
            send_request(mfe_pkg::REQ_START, '0);
            ms = $urandom_range(0, 1000);
            len = $urandom_range(3, 20);
            for (int i = 0; i < len; i++) begin
                d = random_event();
                if ($urandom_range(0, 4) != 0) begin
                    ms += $urandom_range(0, 3000);
                    d[31:0] = ms;
                end
                if ($urandom_range(0, 29) == 0)
                    send_request(mfe_pkg::req_t'($urandom_range(0, 3)), d);
                else
                    send_request(mfe_pkg::REQ_EVENT, d, stall_free);
            end
            send_request(mfe_pkg::REQ_END, 80'($urandom));
            sent += len + 2;
        end
        stall_free = 1'b0;
    endtask

    // Compare each output transaction against the oldest predicted byte and
    // draw how long the next byte waits for ready.
    always @(posedge aclk) begin
        file_byte_t fb;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected byte %h flag %b last %b",
                                 m_tdata, m_tuser, m_tlast);
                end else begin
                    fb = pending_bytes.pop_front();
                    if (fb.data !== m_tdata || fb.len_flag !== m_tuser ||
                        fb.last !== m_tlast) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Byte: expected %h/%b/%b got %h/%b/%b",
                                     fb.data, fb.len_flag, fb.last,
                                     m_tdata, m_tuser, m_tlast);
                    end
                end
                out_wait = stall_free ? 0 : $urandom_range(0, 18);
            end else if (m_tvalid && out_wait > 0) begin
                out_wait--;
            end
            m_tready <= (out_wait == 0);
        end
    end

    initial begin
        ppq = 15'd480;
        tempo = 24'd500000;
        prev_tick = '0;
        track_len = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        // Hold off until the block has delivered everything.
        drain();
        test_config_extremes();
        test_random_tracks();
        drain();
        if (pending_bytes.size() == 0 && mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mfe_pkg.sv
hdl/mfe_ctrl.sv
hdl/mfe_dp.sv
hdl/midi_file_event_encoder_top.sv
test/tb.sv
